/* hdl/four_key_release_debouncer_chords_unit_macros.svh */
// Assertion helpers shared by the debouncer RTL.
// Each macro expects clk_i and rst_ni in scope.
`ifndef FOUR_KEY_RELEASE_DEBOUNCER_CHORDS_UNIT_MACROS_SVH
`define FOUR_KEY_RELEASE_DEBOUNCER_CHORDS_UNIT_MACROS_SVH

// Same-cycle implication.
`define FKRD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FKRD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/fkrd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package fkrd_pkg;

  localparam int unsigned TimeWidth  = 32;
  localparam int unsigned NumKeys    = 4;
  localparam int unsigned DbWidth    = 16;
  localparam int unsigned EventWidth = 3;
  localparam int unsigned CmpWidth   = (TimeWidth > DbWidth) ? TimeWidth : DbWidth;
  localparam int unsigned InWidth    = ((NumKeys + TimeWidth + 7) / 8) * 8;
  localparam int unsigned OutWidth   = ((EventWidth + 7) / 8) * 8;

  localparam logic [DbWidth-1:0] DebounceReset = DbWidth'(50);

  localparam int unsigned IdxEsc   = 0;
  localparam int unsigned IdxUp    = 1;
  localparam int unsigned IdxDown  = 2;
  localparam int unsigned IdxEnter = 3;

  typedef enum logic [EventWidth-1:0] {
    KeyNone      = 3'd0,
    KeyEsc       = 3'd1,
    KeyUp        = 3'd2,
    KeyDown      = 3'd3,
    KeyEnter     = 3'd4,
    KeyChordUp   = 3'd5,
    KeyChordDown = 3'd6
  } key_event_e;

  typedef logic [TimeWidth-1:0] time_t;

  typedef struct packed {
    logic [NumKeys-1:0]  held;
    time_t [NumKeys-1:0] low_time;
  } key_state_t;

  // Packed to match the input tdata layout: levels in the low bits.
  typedef struct packed {
    time_t              now;
    logic [NumKeys-1:0] level;
  } poll_t;

endpackage

`default_nettype wire

/* hdl/fkrd_eval.sv */
`timescale 1ns / 1ps
`default_nettype none

module fkrd_eval import fkrd_pkg::*; (
  input  key_state_t         state_i,
  input  poll_t              poll_i,
  input  logic [DbWidth-1:0] debounce_i,
  output key_state_t         state_o,
  output key_event_e         event_o
);

  function automatic logic expired(input time_t now, input time_t last,
                                   input logic [DbWidth-1:0] db);
    time_t diff;
    diff = now - last;
    return CmpWidth'(diff) > CmpWidth'(db);
  endfunction

  always_comb begin
    key_state_t st;
    key_event_e ev;
    time_t      now;
    st  = state_i;
    ev  = KeyNone;
    now = poll_i.now;

    // Escape
    if (!poll_i.level[IdxEsc]) begin
      st.held[IdxEsc]     = 1'b1;
      st.low_time[IdxEsc] = now;
    end else if (st.held[IdxEsc] && expired(now, st.low_time[IdxEsc], debounce_i)) begin
      st.held[IdxEsc] = 1'b0;
      ev              = KeyEsc;
    end

    // Up: chord with a held enter consumes enter
    if (!poll_i.level[IdxUp]) begin
      st.held[IdxUp]     = 1'b1;
      st.low_time[IdxUp] = now;
    end else if (st.held[IdxUp] && expired(now, st.low_time[IdxUp], debounce_i)) begin
      st.held[IdxUp] = 1'b0;
      if (st.held[IdxEnter]) begin
        ev                    = KeyChordUp;
        st.held[IdxEnter]     = 1'b0;
        st.low_time[IdxEnter] = now;
      end else begin
        ev = KeyUp;
      end
    end

    // Down: sees enter as left by the up check
    if (!poll_i.level[IdxDown]) begin
      st.held[IdxDown]     = 1'b1;
      st.low_time[IdxDown] = now;
    end else if (st.held[IdxDown] && expired(now, st.low_time[IdxDown], debounce_i)) begin
      st.held[IdxDown] = 1'b0;
      if (st.held[IdxEnter]) begin
        ev                    = KeyChordDown;
        st.held[IdxEnter]     = 1'b0;
        st.low_time[IdxEnter] = now;
      end else begin
        ev = KeyDown;
      end
    end

    // Enter: chord with a held up consumes up, enter time still advances
    if (!poll_i.level[IdxEnter]) begin
      st.held[IdxEnter]     = 1'b1;
      st.low_time[IdxEnter] = now;
    end else if (st.held[IdxEnter] &&
                 expired(now, st.low_time[IdxEnter], debounce_i)) begin
      st.held[IdxEnter] = 1'b0;
      if (st.held[IdxUp]) begin
        ev                    = KeyChordUp;
        st.held[IdxUp]        = 1'b0;
        st.low_time[IdxEnter] = now;
      end else begin
        ev = KeyEnter;
      end
    end

    state_o = st;
    event_o = ev;
  end

endmodule

`default_nettype wire

/* hdl/four_key_release_debouncer_chords_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Handshake                  Payload
// s_axis    in   s_axis_tvalid/tready       tdata: esc, up, down, enter levels, now_ms
// m_axis    out  m_axis_tvalid/tready       tdata: key_event
// cfg       in   cfg_valid_i/cfg_ready_o    cfg_data_i: debounce_ms
//
// One poll per cycle while s_axis_tready is high; its key event is registered on acceptance.
// Throughput is set by the single evaluation stage feeding a two-entry output buffer.
// Reset clears key state, debounce_ms to 50 and both output entries.
// A stalled output fills the skid entry; s_axis_tready drops only when both are full.
// Configuration writes are taken in every cycle.

`include "four_key_release_debouncer_chords_unit_macros.svh"

module four_key_release_debouncer_chords_unit import fkrd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [0] esc_level, [1] up_level, [2] down_level, [3] enter_level, [35:4] now_ms
  input  logic [InWidth-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [2:0] key_event
  output logic [OutWidth-1:0] m_axis_tdata,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [DbWidth-1:0]  cfg_data_i
);

  key_state_t         state_q, state_d;
  logic [DbWidth-1:0] debounce_q;
  key_event_e         out_q, out_d, skid_q, skid_d;
  logic               out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  key_event_e         new_event;
  poll_t              poll;
  logic               s_accept, m_take;

  assign poll          = poll_t'(s_axis_tdata[NumKeys+TimeWidth-1:0]);
  assign s_axis_tready = !skid_valid_q;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign m_take        = m_axis_tvalid && m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  fkrd_eval u_eval (
    .state_i    (state_q),
    .poll_i     (poll),
    .debounce_i (debounce_q),
    .state_o    (state_d),
    .event_o    (new_event)
  );

  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (skid_valid_q) begin
      if (m_take) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (out_valid_q && !m_take) begin
      // park the new item behind the waiting one
      if (s_accept) begin
        skid_d       = new_event;
        skid_valid_d = 1'b1;
      end
    end else begin
      out_valid_d = s_accept;
      if (s_accept) begin
        out_d = new_event;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= '0;
      debounce_q   <= DebounceReset;
      out_q        <= KeyNone;
      skid_q       <= KeyNone;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (s_accept) begin
        state_q <= state_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        debounce_q <= cfg_data_i;
      end
      out_q        <= out_d;
      skid_q       <= skid_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutWidth-EventWidth){1'b0}}, out_q};

  `FKRD_ASSERT_NOW(a_skid_behind_out, skid_valid_q, out_valid_q, "skid full while output empty")
  `FKRD_ASSERT_NEXT(a_state_only_on_accept, !s_accept, $stable(state_q), "key state moved without poll")
  `FKRD_ASSERT_NEXT(a_esc_low_holds, s_accept && !s_axis_tdata[IdxEsc], state_q.held[IdxEsc], "escape low not held")
  `FKRD_ASSERT_NEXT(a_enter_low_time, s_accept && !s_axis_tdata[IdxEnter], state_q.held[IdxEnter] && (state_q.low_time[IdxEnter] == $past(poll.now)), "enter low time not recorded")

endmodule

`default_nettype wire

/* test/tb_four_key_release_debouncer_chords_unit.sv */
`timescale 1ns / 1ps

module tb_four_key_release_debouncer_chords_unit;
  import fkrd_pkg::*;

  localparam int unsigned PollBits      = $bits(poll_t);
  localparam int unsigned QuietLimit    = 2000;
  localparam int unsigned ItemsPerPhase = 206;
  localparam int unsigned MaxReported   = 40;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  // [0] esc, [1] up, [2] down, [3] enter levels, [35:4] now_ms
  logic [InWidth-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  // [2:0] key_event
  logic [OutWidth-1:0] m_axis_tdata;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [DbWidth-1:0]  cfg_data_i    = '0;

  poll_t      poll_q[$];
  key_event_e key_event_q[$];

  // Local copy of the debouncer state
  logic [NumKeys-1:0] held_model;
  time_t              low_time_model [NumKeys];
  logic [DbWidth-1:0] debounce_model;

  int unsigned send_idle_pct  = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned hold_cycles    = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned error_count    = 0;

  four_key_release_debouncer_chords_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Update one key; return 1 when its debounced release fires.
  function automatic logic key_released(input int unsigned k, input logic level,
                                         input time_t now);
    time_t elapsed;
    if (!level) begin
      held_model[k]     = 1'b1;
      low_time_model[k] = now;
      return 1'b0;
    end
    elapsed = now - low_time_model[k];
    if (held_model[k] && elapsed > time_t'(debounce_model)) begin
      held_model[k] = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic key_event_e poll_key_event(input poll_t p);
    key_event_e code;
    code = KeyNone;
    if (key_released(IdxEsc, p.level[IdxEsc], p.now)) code = KeyEsc;
    if (key_released(IdxUp, p.level[IdxUp], p.now)) begin
      if (held_model[IdxEnter]) begin
        code = KeyChordUp;
        held_model[IdxEnter]     = 1'b0;
        low_time_model[IdxEnter] = p.now;
      end else begin
        code = KeyUp;
      end
    end
    if (key_released(IdxDown, p.level[IdxDown], p.now)) begin
      if (held_model[IdxEnter]) begin
        code = KeyChordDown;
        held_model[IdxEnter]     = 1'b0;
        low_time_model[IdxEnter] = p.now;
      end else begin
        code = KeyDown;
      end
    end
    // Enter chord clears up but stamps enter's time
    if (key_released(IdxEnter, p.level[IdxEnter], p.now)) begin
      if (held_model[IdxUp]) begin
        code = KeyChordUp;
        held_model[IdxUp]        = 1'b0;
        low_time_model[IdxEnter] = p.now;
      end else begin
        code = KeyEnter;
      end
    end
    return code;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    error_count++;
    if (error_count <= MaxReported)
      $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Driver: offer queued polls, predict on acceptance
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) debounce_model = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready)
        key_event_q.push_back(poll_key_event(poll_t'(s_axis_tdata[PollBits-1:0])));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (poll_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
          s_axis_tdata  <= InWidth'(poll_q.pop_front());
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each key event with the oldest prediction
  always @(posedge clk_i) begin : check_events
    key_event_e want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (key_event_q.size() == 0) begin
        report_mismatch("key event with no poll pending", m_axis_tdata[EventWidth-1:0], 0);
      end else begin
        want = key_event_q.pop_front();
        if (m_axis_tdata[EventWidth-1:0] !== want)
          report_mismatch("key_event", m_axis_tdata[EventWidth-1:0], want);
      end
    end
    m_axis_tready <= (hold_cycles == 0) && ($urandom_range(99, 0) >= sink_stall_pct);
  end

  // Count down a long receiver hold-off
  always @(posedge clk_i) begin
    if (hold_cycles != 0) hold_cycles <= hold_cycles - 1;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QuietLimit) begin
      $display("%0t: no handshake for %0d cycles", $time, QuietLimit);
      $display("tb_four_key_release_debouncer_chords_unit: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_poll(input logic [NumKeys-1:0] level, input time_t now);
    poll_t p;
    p.level = level;
    p.now   = now;
    poll_q.push_back(p);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (poll_q.size() != 0 || s_axis_tvalid || key_event_q.size() != 0);
  endtask

  task automatic set_debounce(input logic [DbWidth-1:0] value);
    @(posedge clk_i);
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Mostly key press/release runs with time steps around the debounce
  // window; a few polls are pure noise.
  task automatic queue_key_activity(input int unsigned count, input int unsigned db);
    logic [NumKeys-1:0] level;
    time_t              now;
    int unsigned        span;
    level = '1;
    now   = $urandom;
    span  = db;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99, 0) < 8) begin
        level = NumKeys'($urandom);
        now   = $urandom;
      end else begin
        for (int k = 0; k < NumKeys; k++)
          if ($urandom_range(99, 0) < ((k == IdxEnter) ? 12 : 25)) level[k] = ~level[k];
        case ($urandom_range(19, 0))
          0, 1:    ;
          2, 3:    now = now + 1;
          4, 5:    now = now + span;
          6, 7:    now = now + span + 1;
          8:       now = '1 - $urandom_range(span / 2 + 1, 0);
          9, 10:   now = now + $urandom_range(span + span / 2 + 2, span / 2);
          default: now = now + $urandom_range(span / 2 + 1, 0);
        endcase
      end
      queue_poll(level, now);
    end
  endtask

  initial begin
    int unsigned db;
    held_model     = '0;
    debounce_model = DebounceReset;
    foreach (low_time_model[k]) low_time_model[k] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset debounce of 50: boundary, overwrite order, chords, wrap
    queue_poll(4'b1111, 0);
    queue_poll(4'b0000, 10);
    queue_poll(4'b1111, 60);
    queue_poll(4'b1111, 61);
    queue_poll(4'b0101, 100);
    queue_poll(4'b1101, 200);
    queue_poll(4'b1111, 300);
    queue_poll(4'b0011, 400);
    queue_poll(4'b0111, 460);
    queue_poll(4'b1111, 520);
    queue_poll(4'b1110, 32'hFFFF_FFF0);
    queue_poll(4'b1111, 32'h0000_0030);
    queue_poll(4'b1101, 32'h0000_0040);
    queue_poll(4'b1111, 32'h0000_0072);
    queue_poll(4'b1111, 32'h0000_0073);
    wait_idle();
    set_debounce('0);
    queue_poll(4'b1011, 1000);
    queue_poll(4'b1111, 1000);
    queue_poll(4'b1111, 1001);
    wait_idle();
    set_debounce('1);
    queue_poll(4'b1110, 0);
    queue_poll(4'b1111, 65535);
    queue_poll(4'b1111, 65536);
    queue_poll(4'b0000, 32'hFFFF_FFFF);
    queue_poll(4'b1111, 0);

    for (int phase = 0; phase < 8; phase++) begin
      wait_idle();
      case (phase)
        0:       db = 50;
        1:       db = 0;
        2:       db = 65535;
        3:       db = 1;
        4:       db = $urandom_range(300, 2);
        5:       db = 65534;
        6:       db = 7;
        default: db = $urandom_range(65535, 0);
      endcase
      set_debounce(DbWidth'(db));
      case (phase % 4)
        0:       begin send_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin send_idle_pct = 85; sink_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  sink_stall_pct = 85; end
        default: begin send_idle_pct = 17; sink_stall_pct = 17; end
      endcase
      // Hold the result side off while polls keep coming
      if (phase == 0) hold_cycles = 300;
      queue_key_activity(ItemsPerPhase, db);
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_four_key_release_debouncer_chords_unit: done, clean");
    end else begin
      $display("tb_four_key_release_debouncer_chords_unit: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/fkrd_pkg.sv
hdl/fkrd_eval.sv
hdl/four_key_release_debouncer_chords_unit.sv
test/tb_four_key_release_debouncer_chords_unit.sv
